// ----- design/assert_macros.svh -----
// assertion helpers for the converter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/f2pcm_pkg.sv -----
`default_nettype none

package f2pcm_pkg;

    localparam logic [2:0] FMT_S8    = 3'd0;
    localparam logic [2:0] FMT_U8    = 3'd1;
    localparam logic [2:0] FMT_S16   = 3'd2;
    localparam logic [2:0] FMT_U16   = 3'd3;
    localparam logic [2:0] FMT_S32   = 3'd4;
    localparam logic [2:0] FMT_FLOAT = 3'd5;

    localparam logic [0:0] REG_FORMAT = 1'd0;
    localparam logic [0:0] REG_ENDIAN = 1'd1;

    typedef struct packed {
        logic [2:0] sample_format;
        logic       big_endian_out;
    } cfg_t;

endpackage

`default_nettype wire

// ----- design/float_to_pcm_sample_converter_top.sv -----
`default_nettype none

// channel   | direction | payload
// s_axis    | in        | tdata[31:0] sample_bits
// m_axis    | out       | tdata[31:0] pcm_word, tdata[34:32] byte_count
// cfg       | in        | index 0 sample_format, 1 big_endian_out
//
// one sample per cycle while the output is not stalled; samples pass an input register, then a result register
// rst_n clears valids and sets format s16, little endian
// a stalled result holds while the input register may still take one sample
// s_axis_tready drops only when both registers are full and output stalls

module float_to_pcm_sample_converter_top
    import f2pcm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // sample_bits
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,   // pcm_word, byte_count, zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

`include "assert_macros.svh"

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [31:0] in_data_reg;
    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [2:0]  out_count_reg;
    logic [31:0] conv_word;
    logic [2:0]  conv_count;
    logic        out_load;

    assign cfg_ready = 1'b1;
    assign out_load = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;

    f2pcm_convert u_convert (
        .sample_bits (in_data_reg),
        .cfg         (cfg_reg),
        .pcm_word    (conv_word),
        .byte_count  (conv_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_format  <= FMT_S16;
            cfg_reg.big_endian_out <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_FORMAT)
                cfg_reg.sample_format <= cfg_data[2:0];
            if (cfg_valid && cfg_index == REG_ENDIAN)
                cfg_reg.big_endian_out <= cfg_data[0];
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_data_reg <= s_axis_tdata;
        if (out_load)
        begin
            out_word_reg  <= conv_word;
            out_count_reg <= conv_count;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_count_reg, out_word_reg};

    `ASSERT_NEXT(a_load_valid, clk, rst_n, out_load, out_valid_reg,
        "result register not valid after load")
    `ASSERT_IMPL(a_full_stall, clk, rst_n, in_valid_reg && out_valid_reg && !m_axis_tready,
        !s_axis_tready, "input taken while both registers stalled")
    `ASSERT_IMPL(a_count_legal, clk, rst_n, out_valid_reg,
        out_count_reg == 3'd1 || out_count_reg == 3'd2 || out_count_reg == 3'd4,
        "illegal byte count")

endmodule

`default_nettype wire

// ----- design/f2pcm_convert.sv -----
`default_nettype none

// combinational float to pcm conversion for one sample
module f2pcm_convert
    import f2pcm_pkg::*;
(
    input  wire logic [31:0] sample_bits,
    input  wire cfg_t        cfg,
    output logic      [31:0] pcm_word,
    output logic      [2:0]  byte_count
);

    logic        sgn;
    logic [7:0]  expo;
    logic [22:0] frac;
    logic        is_nan;
    logic        ge_one;
    logic        lt_mone;
    logic [5:0]  nbits;
    logic        is_signed;
    logic        is_int;
    logic [23:0] mant;
    logic [7:0]  e1;
    logic [8:0]  s_amt;
    logic [31:0] mag;
    logic [7:0]  t_amt;
    logic [47:0] rw;
    logic [23:0] rq;
    logic        rnd_up;
    logic [24:0] rmag;
    logic [31:0] rext;
    logic [31:0] ceil_part;
    logic [31:0] half;
    logic [31:0] mask;
    logic [31:0] maxw;
    logic [31:0] minw;
    logic [31:0] ival;
    logic [31:0] usum;
    logic [31:0] word;

    always_comb
    begin
        sgn   = sample_bits[31];
        expo  = sample_bits[30:23];
        frac  = sample_bits[22:0];
        is_nan = (expo == 8'hFF) && (frac != 23'd0);
        ge_one  = !sgn && (expo >= 8'd127) && !is_nan;
        lt_mone = sgn && !is_nan && ((expo > 8'd127) || (expo == 8'd127 && frac != 23'd0));
        mant = {(expo != 8'd0), frac};
        // subnormals share the scale of the smallest normal exponent
        e1 = (expo == 8'd0) ? 8'd1 : expo;

        case (cfg.sample_format)
            FMT_S8:  begin nbits = 6'd8;  is_signed = 1'b1; is_int = 1'b1; end
            FMT_U8:  begin nbits = 6'd8;  is_signed = 1'b0; is_int = 1'b1; end
            FMT_S16: begin nbits = 6'd16; is_signed = 1'b1; is_int = 1'b1; end
            FMT_U16: begin nbits = 6'd16; is_signed = 1'b0; is_int = 1'b1; end
            FMT_S32: begin nbits = 6'd32; is_signed = 1'b1; is_int = 1'b1; end
            default: begin nbits = 6'd32; is_signed = 1'b0; is_int = 1'b0; end
        endcase

        half = 32'd1 << (nbits - 6'd1);
        mask = (nbits == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 32'd1);
        maxw = is_signed ? (half - 32'd1) : mask;
        minw = is_signed ? half : 32'd0;

        // |x| * 2^(n-1) truncated; exponents above 127 are saturated below
        s_amt = 9'd159 - {1'b0, e1} - {3'd0, nbits};
        mag = {mant, 8'd0} >> s_amt;

        // float32 sum rounds on a grid of 2^(n-24) above half, 2^(n-25) below,
        // so round |x| * 2^23 or |x| * 2^24 to nearest even first
        t_amt = sgn ? (8'd126 - e1) : (8'd127 - e1);
        rw = {mant, 24'd0} >> t_amt;
        rq = rw[47:24];
        rnd_up = rw[23] && ((rw[22:0] != 23'd0) || rq[0]);
        rmag = {1'b0, rq} + {24'd0, rnd_up};
        if (sgn && expo >= 8'd127)
            rmag = 25'h100_0000;
        rext = {7'd0, rmag};

        // below half the truncated sum is half minus the rounded part, rounded up
        if (nbits == 6'd8)
            ceil_part = (rext + 32'h0001_FFFF) >> 17;
        else
            ceil_part = (rext + 32'h0000_01FF) >> 9;
        if (sgn)
            usum = half - ceil_part;
        else if (nbits == 6'd8)
            usum = half + (rext >> 16);
        else
            usum = half + (rext >> 8);

        if (is_signed)
            ival = sgn ? (32'd0 - mag) : mag;
        else if (usum > mask)
            ival = maxw;
        else
            ival = usum;

        if (!is_int)
            word = sample_bits;
        else if (is_nan)
            word = 32'd0;
        else if (ge_one)
            word = maxw;
        else if (lt_mone)
            word = minw;
        else
            word = ival & mask;

        if (!is_int)
            byte_count = 3'd4;
        else if (nbits == 6'd8)
            byte_count = 3'd1;
        else if (nbits == 6'd16)
            byte_count = 3'd2;
        else
            byte_count = 3'd4;

        if (cfg.big_endian_out && byte_count == 3'd2)
            pcm_word = {16'd0, word[7:0], word[15:8]};
        else if (cfg.big_endian_out && byte_count == 3'd4)
            pcm_word = {word[7:0], word[15:8], word[23:16], word[31:24]};
        else
            pcm_word = word;
    end

endmodule

`default_nettype wire

// ----- bench/tb_float_to_pcm_sample_converter_top.sv -----
`timescale 1ns / 1ps

module tb_float_to_pcm_sample_converter_top;
    import f2pcm_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // sample_bits
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // pcm_word, byte_count, zero pad
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    logic [31:0] sample_q[$];
    logic [39:0] pcm_expected_q[$];
    cfg_t        cfg_shadow;
    int          tx_idle_pct;
    int          rx_stall_pct;
    bit          tx_hold;
    bit          rx_hold_go;
    int          rx_hold_left;
    int          error_count;

    float_to_pcm_sample_converter_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // exact float32 to integer conversion, fixed point with 200 fraction bits
    function automatic logic [31:0] float_to_int_word(logic [31:0] b, int nb, bit sgn);
        logic [255:0] fx;
        logic [255:0] s;
        logic [255:0] r;
        logic [255:0] rem;
        logic [255:0] halfb;
        logic [31:0]  half;
        logic [31:0]  mask;
        logic [31:0]  maxw;
        logic [31:0]  minw;
        logic [31:0]  mag;
        int           e;
        int           p;
        int           sh;
        half = 32'h1 << (nb - 1);
        mask = (nb == 32) ? 32'hFFFF_FFFF : ((32'h1 << nb) - 32'h1);
        maxw = sgn ? half - 32'h1 : mask;
        minw = sgn ? half : 32'h0;
        if (b[30:23] == 8'hFF && b[22:0] != 23'h0)
            return 32'h0;
        if (!b[31] && b[30:0] >= 31'h3F80_0000)
            return maxw;
        if (b[31] && b[30:0] > 31'h3F80_0000)
            return minw;
        e = b[30:23];
        if (e == 0)
        begin
            fx = 256'(b[22:0]);
            sh = 51;
        end
        else
        begin
            fx = 256'({1'b1, b[22:0]});
            sh = e + 50;
        end
        fx = (fx << sh) << (nb - 1);
        if (sgn)
        begin
            mag = fx[231:200];
            return b[31] ? ((~mag + 32'h1) & mask) : (mag & mask);
        end
        s = b[31] ? ((256'(half) << 200) - fx) : ((256'(half) << 200) + fx);
        if (s == 256'h0)
            return 32'h0;
        p = 0;
        for (int i = 0; i < 256; i++)
            if (s[i])
                p = i;
        // round the sum to 24 significant bits, nearest even
        if (p > 23)
        begin
            sh = p - 23;
            r = s >> sh;
            rem = s & ((256'h1 << sh) - 256'h1);
            halfb = 256'h1 << (sh - 1);
            if (rem > halfb || (rem == halfb && r[0]))
                r = r + 256'h1;
            r = r << sh;
        end
        else
            r = s;
        if (r >= (256'h1 << (200 + nb)))
            return maxw;
        return r[231:200] & mask;
    endfunction

    function automatic logic [39:0] pcm_of_sample(logic [31:0] b, cfg_t c);
        logic [31:0] word;
        logic [2:0]  n;
        case (c.sample_format)
            FMT_S8:  begin word = float_to_int_word(b, 8, 1'b1);  n = 3'd1; end
            FMT_U8:  begin word = float_to_int_word(b, 8, 1'b0);  n = 3'd1; end
            FMT_S16: begin word = float_to_int_word(b, 16, 1'b1); n = 3'd2; end
            FMT_U16: begin word = float_to_int_word(b, 16, 1'b0); n = 3'd2; end
            FMT_S32: begin word = float_to_int_word(b, 32, 1'b1); n = 3'd4; end
            default: begin word = b;                             n = 3'd4; end
        endcase
        if (c.big_endian_out && n == 3'd2)
            word = {16'h0, word[7:0], word[15:8]};
        else if (c.big_endian_out && n == 3'd4)
            word = {word[7:0], word[15:8], word[23:16], word[31:24]};
        return {5'h0, n, word};
    endfunction

    task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // sample driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                pcm_expected_q.push_back(pcm_of_sample(s_axis_tdata, cfg_shadow));
                void'(sample_q.pop_front());
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (sample_q.size() > 0 && !tx_hold && $urandom_range(99) >= tx_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= sample_q[0];
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (rx_hold_go)
            rx_hold_left <= 400;
        else if (rx_hold_left > 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pcm_expected_q.size() == 0)
                    report_mismatch("unexpected transfer", m_axis_tdata, 40'h0);
                else
                begin
                    logic [39:0] want;
                    want = pcm_expected_q.pop_front();
                    if (m_axis_tdata[31:0] != want[31:0])
                        report_mismatch("pcm_word", m_axis_tdata, want);
                    if (m_axis_tdata[34:32] != want[34:32])
                        report_mismatch("byte_count", m_axis_tdata, want);
                    if (m_axis_tdata[39:35] != want[39:35])
                        report_mismatch("pad", m_axis_tdata, want);
                end
            end
            m_axis_tready <= (rx_hold_left == 0 && !rx_hold_go
                              && $urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_FORMAT)
            cfg_shadow.sample_format = val[2:0];
        else
            cfg_shadow.big_endian_out = val[0];
    endtask

    task automatic wait_drained();
        while (sample_q.size() > 0 || pcm_expected_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] random_sample();
        logic [31:0] b;
        int          pick;
        b = $urandom;
        pick = $urandom_range(9);
        // mostly near the audio range, some fully random patterns
        if (pick < 6)
            b[30:23] = 8'($urandom_range(127, 100));
        else if (pick < 8)
            b[30:23] = 8'($urandom_range(128, 115));
        return b;
    endfunction

    logic [31:0] corner_samples[] = '{
        32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
        32'h3F7F_FFFF, 32'hBF7F_FFFF, 32'hBF80_0001, 32'h3F80_0001,
        32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
        32'h0000_0001, 32'h8000_0001, 32'h3F00_0000, 32'hBF00_0000,
        32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3EFF_FFFF, 32'h3C00_0000,
        32'h3F7F_FF80, 32'h3F7F_FE00
    };

    initial
    begin
        int fmt_code;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'h0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_FORMAT;
        cfg_data      = 32'h0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        tx_hold       = 1'b0;
        rx_hold_go    = 1'b0;
        rx_hold_left  = 0;
        error_count   = 0;
        cfg_shadow.sample_format  = FMT_S16;
        cfg_shadow.big_endian_out = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting first, then every format code in both byte orders
        for (int ph = 0; ph < 17; ph++)
        begin
            if (ph > 0)
            begin
                fmt_code = (ph - 1) % 8;
                write_reg(REG_FORMAT, {$urandom} & ~32'h7 | 32'(fmt_code));
                write_reg(REG_ENDIAN, {$urandom} & ~32'h1 | 32'((ph - 1) / 8));
            end
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
                default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
            endcase
            foreach (corner_samples[i])
                sample_q.push_back(corner_samples[i]);
            for (int i = 0; i < 84; i++)
                sample_q.push_back(random_sample());
            if (ph == 4)
            begin
                // receiver holds off while samples keep coming
                @(posedge clk);
                rx_hold_go <= 1'b1;
                @(posedge clk);
                rx_hold_go <= 1'b0;
            end
            if (ph == 6)
            begin
                // sender pauses until the pipeline is empty
                repeat (30) @(posedge clk);
                tx_hold <= 1'b1;
                while (pcm_expected_q.size() > 0 || s_axis_tvalid)
                    @(posedge clk);
                tx_hold <= 1'b0;
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("** float_to_pcm_sample_converter_top: PASSED **");
        else
            $display("** float_to_pcm_sample_converter_top: FAILED **");
        $finish;
    end

    initial
    begin
        #(20 * 400000);
        $display("** float_to_pcm_sample_converter_top: FAILED **");
        $finish;
    end

endmodule

// ----- float_to_pcm_sample_converter_top.f -----
+incdir+design
design/f2pcm_pkg.sv
design/f2pcm_convert.sv
design/float_to_pcm_sample_converter_top.sv
bench/tb_float_to_pcm_sample_converter_top.sv
